### hw/rtl/bsws_pkg.sv
// shared types and constants of the bounded stack with search
`default_nettype none

package bsws_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SLOT_W    = 3;

  // opcodes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // which result the datapath loads into the output register
  typedef enum logic [2:0] {
    EM_FULL,
    EM_EMPTY,
    EM_NOTFOUND,
    EM_PUSH,
    EM_POP,
    EM_LIST,
    EM_PEND,
    EM_PEND_LAST
  } emit_e;

  typedef struct packed {
    logic  load;
    logic  wr;
    logic  pop;
    logic  scan_start;
    logic  scan_step;
    logic  emit;
    emit_e emit_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       full;
    logic       last_idx;
    logic       match;
    logic       pend_vld;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/bsws_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module bsws_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hw/rtl/bsws_ctrl.sv
// control state machine of the bounded stack with search
`default_nettype none

module bsws_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bsws_pkg::sts_t sts_i,
  output bsws_pkg::cmd_t     cmd_o
);
  import bsws_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_POPWAIT  = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       is_list;
  logic       need_emit;

  assign is_list   = (sts_i.op == OP_LIST);
  assign need_emit = is_list || (sts_i.match && sts_i.pend_vld);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit_sel = EM_FULL;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.op)
          OP_PUSH: begin
            if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              if (sts_i.full) begin
                cmd_o.emit_sel = EM_FULL;
              end else begin
                cmd_o.wr       = 1'b1;
                cmd_o.emit_sel = EM_PUSH;
              end
              state_d = S_IDLE;
            end
          end
          OP_POP: begin
            if (!sts_i.empty) begin
              cmd_o.pop = 1'b1;
              state_d   = S_POPWAIT;
            end else if (sts_i.out_free) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = EM_EMPTY;
              state_d        = S_IDLE;
            end
          end
          OP_LIST, OP_SEARCH: begin
            if (!sts_i.empty) begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end else if (sts_i.out_free) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = is_list ? EM_EMPTY : EM_NOTFOUND;
              state_d        = S_IDLE;
            end
          end
        endcase
      end
      S_POPWAIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EM_POP;
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        // a match is held back one step so the final one can carry last
        if (!need_emit || sts_i.out_free) begin
          cmd_o.scan_step = 1'b1;
          cmd_o.emit      = need_emit;
          cmd_o.emit_sel  = is_list ? EM_LIST : EM_PEND;
          if (sts_i.last_idx) begin
            state_d = is_list ? S_IDLE : S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = sts_i.pend_vld ? EM_PEND_LAST : EM_NOTFOUND;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bsws_dp.sv
// datapath: entry store, fill count, scan pointer and output register
`default_nettype none

module bsws_dp #(
  parameter int unsigned DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [bsws_pkg::DATA_W-1:0]   value_i,
  input  wire bsws_pkg::cmd_t                cmd_i,
  output bsws_pkg::sts_t                     sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         status_o,
  output logic [bsws_pkg::SLOT_W-1:0]        slot_o,
  output logic [bsws_pkg::DATA_W-1:0]        entry_value_o,
  output logic                               last_o
);
  import bsws_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [1:0]        op_q;
  logic [DATA_W-1:0] key_q;
  logic [CW-1:0]     count_q;
  logic [AW-1:0]     idx_q;
  logic [AW-1:0]     pend_slot_q;
  logic              pend_vld_q;

  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [SLOT_W-1:0] slot_q;
  logic [DATA_W-1:0] value_q;
  logic              last_q;

  logic [1:0]        status_d;
  logic [SLOT_W-1:0] slot_d;
  logic [DATA_W-1:0] value_d;
  logic              last_d;

  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic [DATA_W-1:0] rd_data;
  logic              last_idx;
  logic              out_free;
  logic [AW+2:0]     idx_ext;
  logic [AW+2:0]     cnt_ext;
  logic [AW+2:0]     pend_ext;

  assign top_addr = AW'(count_q - CW'(1));
  assign last_idx = ((CW'(idx_q) + CW'(1)) == count_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.pop) begin
      rd_en   = 1'b1;
      rd_addr = top_addr;
    end else if (cmd_i.scan_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd_i.scan_step && !last_idx) begin
      rd_en   = 1'b1;
      rd_addr = idx_q + AW'(1);
    end
  end

  bsws_ram #(
    .Width (DATA_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr),
    .wr_addr_i (AW'(count_q)),
    .wr_data_i (key_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign sts_o.op       = op_q;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CW'(DEPTH));
  assign sts_o.last_idx = last_idx;
  assign sts_o.match    = (rd_data == key_q);
  assign sts_o.pend_vld = pend_vld_q;
  assign sts_o.out_free = out_free;

  // slots wrap to three bits
  assign idx_ext  = (AW+3)'(idx_q);
  assign cnt_ext  = (AW+3)'(AW'(count_q));
  assign pend_ext = (AW+3)'(pend_slot_q);

  always_comb begin
    status_d = ST_OK;
    slot_d   = '0;
    value_d  = '0;
    last_d   = 1'b1;
    unique case (cmd_i.emit_sel)
      EM_FULL:      status_d = ST_FULL;
      EM_EMPTY:     status_d = ST_EMPTY;
      EM_NOTFOUND:  status_d = ST_NOTFOUND;
      EM_PUSH: begin
        slot_d  = cnt_ext[SLOT_W-1:0];
        value_d = key_q;
      end
      EM_POP: begin
        slot_d  = idx_ext[SLOT_W-1:0];
        value_d = rd_data;
      end
      EM_LIST: begin
        slot_d  = idx_ext[SLOT_W-1:0];
        value_d = rd_data;
        last_d  = last_idx;
      end
      EM_PEND: begin
        slot_d  = pend_ext[SLOT_W-1:0];
        value_d = key_q;
        last_d  = 1'b0;
      end
      EM_PEND_LAST: begin
        slot_d  = pend_ext[SLOT_W-1:0];
        value_d = key_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= value_i;
    end
    if (cmd_i.pop) begin
      idx_q <= top_addr;
    end else if (cmd_i.scan_start) begin
      idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.scan_step && sts_o.match) begin
      pend_slot_q <= idx_q;
    end
    if (cmd_i.emit) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      value_q  <= value_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_PUSH;
      count_q     <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        op_q <= opcode_i;
      end
      if (cmd_i.wr) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.pop) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.scan_start) begin
        pend_vld_q <= 1'b0;
      end else if (cmd_i.scan_step && sts_o.match) begin
        pend_vld_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_o        = slot_q;
  assign entry_value_o = value_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

### hw/rtl/bounded_stack_with_search_core.sv
// top level of the bounded stack with search
`default_nettype none

// bounded stack of DEPTH 32-bit entries filled from slot 0 upward. each input
// transaction carries an opcode and a value: push appends the value (status
// full when no room), pop returns the top entry (status empty when none),
// list returns every held entry from bottom to top, and search returns the
// slot of every entry equal to the value in ascending order, or one not-found
// result. the final result transaction of an input has last set. one input
// is worked on at a time; entries live in a ram with one registered read
// port: pop waits for its read of the top entry, and list or search read
// one entry per cycle through that port while the output is free for each
// result due. on an empty store pop, list and search answer at once.
// output stall only delays the walk, the pending result waits in the output
// register. slot wraps to three bits when DEPTH exceeds 8. an entry is never
// read before it was written, so the store needs no clearing after reset.
module bounded_stack_with_search_core #(
  parameter int unsigned DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [bsws_pkg::DATA_W-1:0] value_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       status_o,
  output logic [bsws_pkg::SLOT_W-1:0]      slot_o,
  output logic [bsws_pkg::DATA_W-1:0]      entry_value_o,
  output logic                             last_o
);
  import bsws_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: accepts a transaction, then steps the datapath
  bsws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store, fill count, scan pointer, held match and result register
  bsws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .entry_value_o (entry_value_o),
    .last_o        (last_o)
  );

  // a result is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over an untaken result");

  // one input at a time: the input side closes right after a transaction
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second input taken while busy");

  // never write past the top
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> !sts.full)
    else $error("push into a full store");

  // a pop never happens on an empty store
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !sts.empty)
    else $error("pop from an empty store");

endmodule

`default_nettype wire

### test/tb_bounded_stack_with_search_core.sv
`timescale 1ns / 1ps
// testbench of the bounded stack with search core: directed and random commands, checked results
module tb_bounded_stack_with_search_core;
  import bsws_pkg::*;

  localparam int unsigned STACK_DEPTH    = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  // list or search over a full store plus pipeline slack
  localparam int unsigned SETTLE_CYCLES  = 3 * STACK_DEPTH + 16;
  localparam int unsigned BACKLOG_CYCLES = 300;

  // one result transaction as the core should give it
  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] entry_value;
    logic              last;
  } stack_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic [1:0]        opcode_i      = OP_PUSH;
  logic [DATA_W-1:0] value_i       = '0;
  logic              out_stall_i   = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [1:0]        status_o;
  logic [SLOT_W-1:0] slot_o;
  logic [DATA_W-1:0] entry_value_o;
  logic              last_o;

  // shadow copy of the stack, updated when an input transaction is accepted
  logic [DATA_W-1:0] model_entries [STACK_DEPTH];
  int unsigned       model_fill = 0;
  stack_result_t     expected_results [$];

  int unsigned error_count      = 0;
  int unsigned cycle_count      = 0;
  int unsigned send_idle_pct    = 13;
  int unsigned recv_idle_pct    = 64;
  int unsigned backlog_requests = 0;
  int unsigned backlog_served   = 0;

  bounded_stack_with_search_core #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .entry_value_o(entry_value_o),
    .last_o       (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop if the core hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void expect_result(input logic [1:0] status, input int unsigned idx,
                                        input logic [DATA_W-1:0] data, input logic is_last);
    stack_result_t res;
    res.status      = status;
    res.slot        = SLOT_W'(idx);
    res.entry_value = data;
    res.last        = is_last;
    expected_results.push_back(res);
  endfunction

  // works out the results of one accepted command and updates the shadow stack
  function automatic void predict_command(input logic [1:0] op, input logic [DATA_W-1:0] val);
    int unsigned hits;
    stack_result_t res;
    hits = 0;
    case (op)
      OP_PUSH: begin
        if (model_fill >= STACK_DEPTH) begin
          expect_result(ST_FULL, 0, '0, 1'b1);
        end else begin
          model_entries[model_fill] = val;
          expect_result(ST_OK, model_fill, val, 1'b1);
          model_fill++;
        end
      end
      OP_POP: begin
        if (model_fill == 0) begin
          expect_result(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          model_fill--;
          expect_result(ST_OK, model_fill, model_entries[model_fill], 1'b1);
        end
      end
      OP_LIST: begin
        if (model_fill == 0) begin
          expect_result(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < model_fill; i++) begin
            expect_result(ST_OK, i, model_entries[i], (i + 1 == model_fill));
          end
        end
      end
      default: begin
        for (int unsigned i = 0; i < model_fill; i++) begin
          if (model_entries[i] == val) begin
            expect_result(ST_OK, i, val, 1'b0);
            hits++;
          end
        end
        if (hits == 0) begin
          expect_result(ST_NOTFOUND, 0, '0, 1'b1);
        end else begin
          // only the final match closes the run
          res = expected_results.pop_back();
          res.last = 1'b1;
          expected_results.push_back(res);
        end
      end
    endcase
  endfunction

  // offers one command, with random idle cycles first, and returns at the accepting edge
  task automatic send_command(input logic [1:0] op, input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_command(op, val);
  endtask

  // values that hit the corners, repeat often, or are fully random
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      case ($urandom_range(4))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        3:       return 32'hFFFF_FFFF;
        default: return 32'd5;
      endcase
    end
    if (sel <= 3) return DATA_W'($urandom_range(7));
    return $urandom;
  endfunction

  // mix of commands; the push share changes every few commands so the stack
  // swings between empty and full, and most searches use a held key
  task automatic send_random_commands(input int unsigned count);
    int unsigned push_pct;
    logic [1:0] op;
    logic [DATA_W-1:0] val;
    push_pct = 50;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 16 == 0) push_pct = $urandom_range(20, 75);
      if ($urandom_range(99) < push_pct) begin
        op = OP_PUSH;
      end else begin
        case ($urandom_range(2))
          0:       op = OP_POP;
          1:       op = OP_LIST;
          default: op = OP_SEARCH;
        endcase
      end
      val = pick_value();
      if (op == OP_SEARCH && model_fill != 0 && $urandom_range(9) < 6) begin
        val = model_entries[$urandom_range(model_fill - 1)];
      end
      send_command(op, val);
    end
  endtask

  // empty store: pop, list and search all report no data
  task automatic test_empty_store();
    send_command(OP_POP, $urandom);
    send_command(OP_LIST, $urandom);
    send_command(OP_SEARCH, 32'h0000_0000);
  endtask

  // fill with the extremes and repeated values, then push once too many
  task automatic test_fill_to_full();
    send_command(OP_PUSH, 32'h8000_0000);
    send_command(OP_PUSH, 32'h7FFF_FFFF);
    send_command(OP_PUSH, 32'h0000_0000);
    send_command(OP_PUSH, 32'hFFFF_FFFF);
    send_command(OP_PUSH, 32'd5);
    send_command(OP_PUSH, 32'hFFFF_FFFF);
    send_command(OP_PUSH, 32'hA5A5_5A5A);
    send_command(OP_PUSH, 32'hFFFF_FFFF);
    send_command(OP_PUSH, 32'h1234_5678);
  endtask

  // full list, search with several matches, one match and no match
  task automatic test_list_and_search();
    send_command(OP_LIST, $urandom);
    send_command(OP_SEARCH, 32'hFFFF_FFFF);
    send_command(OP_SEARCH, 32'd5);
    send_command(OP_SEARCH, 32'h1234_5678);
  endtask

  task automatic test_drain();
    repeat (STACK_DEPTH) send_command(OP_POP, $urandom);
  endtask

  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    send_random_commands(count);
  endtask

  // receiver holds off for a long stretch while commands keep coming, so the
  // output register fills and the core stalls its input
  task automatic test_backlog();
    backlog_requests++;
    send_random_commands(16);
  endtask

  // result side stall: random, or one long hold when a backlog is requested
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (backlog_served != backlog_requests) begin
        backlog_served++;
        for (int unsigned c = 0; c < BACKLOG_CYCLES; c++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compares each accepted result transaction with the oldest expectation
  always @(posedge clk_i) begin
    stack_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d slot %0d entry_value %h last %0b",
               status_o, slot_o, entry_value_o, last_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          error_count++;
        end
        if (slot_o !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, slot_o);
          error_count++;
        end
        if (entry_value_o !== want.entry_value) begin
          $error("entry_value: expected %h, actual %h", want.entry_value, entry_value_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last_o);
          error_count++;
        end
      end
    end
  end

  initial begin : run_tests
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_store();
    test_fill_to_full();
    test_list_and_search();
    test_drain();
    test_random_phase(13, 64, 125);
    test_backlog();
    test_random_phase(64, 13, 125);
    test_random_phase(0, 0, 125);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/bsws_pkg.sv
hw/rtl/bsws_ram.sv
hw/rtl/bsws_ctrl.sv
hw/rtl/bsws_dp.sv
hw/rtl/bounded_stack_with_search_core.sv
test/tb_bounded_stack_with_search_core.sv
